// ===== src/sct_pkg.sv =====
package sct_pkg;

	localparam int TEXT_CHARS_DEF    = 8;
	localparam int POSITION_BITS_DEF = 16;

	// token kinds
	localparam logic [2:0] KIND_KEYWORD  = 3'd0;
	localparam logic [2:0] KIND_IDENT    = 3'd1;
	localparam logic [2:0] KIND_NUMBER   = 3'd2;
	localparam logic [2:0] KIND_OPERATOR = 3'd3;
	localparam logic [2:0] KIND_STMT_END = 3'd4;
	localparam logic [2:0] KIND_EOF      = 3'd5;
	localparam logic [2:0] KIND_INVALID  = 3'd6;

	// operator codes
	localparam logic [3:0] OP_PLUS  = 4'd0;
	localparam logic [3:0] OP_MINUS = 4'd1;
	localparam logic [3:0] OP_STAR  = 4'd2;
	localparam logic [3:0] OP_SLASH = 4'd3;
	localparam logic [3:0] OP_ASSIGN = 4'd4;
	localparam logic [3:0] OP_LPAREN = 4'd5;
	localparam logic [3:0] OP_RPAREN = 4'd6;
	localparam logic [3:0] OP_LT    = 4'd7;
	localparam logic [3:0] OP_GT    = 4'd8;
	localparam logic [3:0] OP_BANG  = 4'd9;
	localparam logic [3:0] OP_LBRACE = 4'd10;
	localparam logic [3:0] OP_RBRACE = 4'd11;
	localparam logic [3:0] OP_EQEQ  = 4'd12;
	localparam logic [3:0] OP_GE    = 4'd13;
	localparam logic [3:0] OP_LE    = 4'd14;
	localparam logic [3:0] OP_NE    = 4'd15;

	// keyword codes
	localparam logic [3:0] KW_DEF    = 4'd0;
	localparam logic [3:0] KW_EXTERN = 4'd1;
	localparam logic [3:0] KW_IF     = 4'd2;
	localparam logic [3:0] KW_ELSE   = 4'd3;
	localparam logic [3:0] KW_WHILE  = 4'd4;

	// keyword spellings, first character in the low byte
	localparam logic [63:0] KW_DEF_TEXT    = 64'h0000_0000_0066_6564;
	localparam logic [63:0] KW_EXTERN_TEXT = 64'h0000_6e72_6574_7865;
	localparam logic [63:0] KW_IF_TEXT     = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_ELSE_TEXT   = 64'h0000_0000_6573_6c65;
	localparam logic [63:0] KW_WHILE_TEXT  = 64'h0000_0065_6c69_6877;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  code;
		logic [63:0] text;
		logic [7:0]  length;
		logic        trunc;
		logic        last;
	} tok_info_t;

	// {hit, code}
	function automatic logic [4:0] op_lookup(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		case (c)
			8'h2b: r = {1'b1, OP_PLUS};
			8'h2d: r = {1'b1, OP_MINUS};
			8'h2a: r = {1'b1, OP_STAR};
			8'h2f: r = {1'b1, OP_SLASH};
			8'h3d: r = {1'b1, OP_ASSIGN};
			8'h28: r = {1'b1, OP_LPAREN};
			8'h29: r = {1'b1, OP_RPAREN};
			8'h3c: r = {1'b1, OP_LT};
			8'h3e: r = {1'b1, OP_GT};
			8'h21: r = {1'b1, OP_BANG};
			8'h7b: r = {1'b1, OP_LBRACE};
			8'h7d: r = {1'b1, OP_RBRACE};
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// {hit, code}; caller rules out truncated text
	function automatic logic [4:0] kw_lookup(logic [63:0] text, logic [7:0] len);
		logic [4:0] r;
		r = 5'd0;
		if (len == 8'd3 && text == KW_DEF_TEXT)
			r = {1'b1, KW_DEF};
		else if (len == 8'd6 && text == KW_EXTERN_TEXT)
			r = {1'b1, KW_EXTERN};
		else if (len == 8'd2 && text == KW_IF_TEXT)
			r = {1'b1, KW_IF};
		else if (len == 8'd4 && text == KW_ELSE_TEXT)
			r = {1'b1, KW_ELSE};
		else if (len == 8'd5 && text == KW_WHILE_TEXT)
			r = {1'b1, KW_WHILE};
		return r;
	endfunction

endpackage

// ===== src/source_code_tokenizer.sv =====
// Streaming source tokenizer.
//
// Input channel (src_valid / src_stall): one source byte per request,
// byte_in plus end_of_source. A zero byte or end_of_source flushes the
// pending token, emits an end-of-file token and restarts at line 1,
// column 1.
// Output channel (tok_valid / tok_stall): one token per request. A byte
// gives zero, one or two tokens; last_of_run marks the final one.
//
// Path: a byte accepted into the input register is scanned there, and its
// tokens are written into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while each byte gives at most one token
// and the receiver keeps up. A byte that gives two tokens can hold the
// input: the three-entry result queue must have two free slots before
// the input register is scanned.
// Stall: while tok_stall is high the queue fills, then the input
// register holds its byte and src_stall rises.
// Reset: arst_n clears the scanner to idle at line 1, column 1 and
// empties the queue and the input register.
module source_code_tokenizer import sct_pkg::*; #(
	parameter int TEXT_CHARS    = TEXT_CHARS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     src_valid,
	output logic                     src_stall,
	input  logic [7:0]               byte_in,
	input  logic                     end_of_source,
	output logic                     tok_valid,
	input  logic                     tok_stall,
	output logic [2:0]               token_kind,
	output logic [3:0]               token_code,
	output logic [63:0]              token_text,
	output logic [7:0]               token_length,
	output logic                     text_truncated,
	output logic [POSITION_BITS-1:0] start_line,
	output logic [POSITION_BITS-1:0] start_column,
	output logic                     last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       room, proc;

	logic                     res0_v, res1_v;
	tok_info_t                res0, res1, head;
	logic [POSITION_BITS-1:0] res0_line, res0_col, res1_line, res1_col;

	// input register is scanned once the queue has space for two tokens
	assign proc      = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!src_stall)
			valid_s1 <= src_valid;
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_source;
		end
	end

	sct_scan #(
		.TEXT_CHARS   (TEXT_CHARS),
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.proc     (proc),
		.c        (byte_s1),
		.eos      (eos_s1),
		.res0_v   (res0_v),
		.res0     (res0),
		.res0_line(res0_line),
		.res0_col (res0_col),
		.res1_v   (res1_v),
		.res1     (res1),
		.res1_line(res1_line),
		.res1_col (res1_col)
	);

	sct_outq #(
		.POSITION_BITS(POSITION_BITS)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (proc && res0_v),
		.in0      (res0),
		.in0_line (res0_line),
		.in0_col  (res0_col),
		.push1    (proc && res1_v),
		.in1      (res1),
		.in1_line (res1_line),
		.in1_col  (res1_col),
		.room     (room),
		.out_valid(tok_valid),
		.out_stall(tok_stall),
		.out_info (head),
		.out_line (start_line),
		.out_col  (start_column)
	);

	assign token_kind     = head.kind;
	assign token_code     = head.code;
	assign token_text     = head.text;
	assign token_length   = head.length;
	assign text_truncated = head.trunc;
	assign last_of_run    = head.last;

endmodule

// ===== src/sct_scan.sv =====
module sct_scan import sct_pkg::*; #(
	parameter int TEXT_CHARS    = TEXT_CHARS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     proc,
	input  logic [7:0]               c,
	input  logic                     eos,
	output logic                     res0_v,
	output tok_info_t                res0,
	output logic [POSITION_BITS-1:0] res0_line,
	output logic [POSITION_BITS-1:0] res0_col,
	output logic                     res1_v,
	output tok_info_t                res1,
	output logic [POSITION_BITS-1:0] res1_line,
	output logic [POSITION_BITS-1:0] res1_col
);

	localparam int BW = 8 * TEXT_CHARS;
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_IDENT  = 2'd1;
	localparam logic [1:0] MODE_NUMBER = 2'd2;
	localparam logic [1:0] MODE_OPWAIT = 2'd3;
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	logic [1:0]               mode_q, mode_n;
	logic [BW-1:0]            buf_q, buf_n, buf_app;
	logic [7:0]               cnt_q, cnt_n;
	logic [POSITION_BITS-1:0] tline_q, tline_n, tcol_q, tcol_n;
	logic [POSITION_BITS-1:0] cline_q, cline_n, ccol_q, ccol_n;

	logic is_end, is_alpha, is_digit, is_skip, is_opw;
	logic [4:0] op_c, op_f, kw;
	logic [3:0] pair_code;
	logic       pair_hit, fl_trunc, done, flush;
	tok_info_t  fl, a, b;
	logic       a_v, b_v;
	logic [POSITION_BITS-1:0] b_line, b_col;

	assign is_end   = eos || (c == 8'h00);
	assign is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign is_skip  = (c == 8'h20) || (c == 8'h2c) || (c >= 8'h09 && c <= 8'h0d);
	assign is_opw   = (c == 8'h3d) || (c == 8'h3c) || (c == 8'h3e);
	assign op_c     = op_lookup(c);
	assign op_f     = op_lookup(buf_q[7:0]);
	assign fl_trunc = cnt_q > 8'(TEXT_CHARS);
	assign kw       = kw_lookup(64'(buf_q), cnt_q);

	// two-character operators: first char pending, c completes it
	always_comb begin
		pair_hit  = 1'b1;
		pair_code = OP_EQEQ;
		if (c == 8'h3d && buf_q[7:0] == 8'h3d)
			pair_code = OP_EQEQ;
		else if (c == 8'h3d && buf_q[7:0] == 8'h3e)
			pair_code = OP_GE;
		else if (c == 8'h3d && buf_q[7:0] == 8'h3c)
			pair_code = OP_LE;
		else if (c == 8'h3e && buf_q[7:0] == 8'h3c)
			pair_code = OP_NE;
		else
			pair_hit = 1'b0;
	end

	// append c at the next free character slot
	always_comb begin
		buf_app = buf_q;
		for (int i = 0; i < TEXT_CHARS; i++) begin
			if (cnt_q == 8'(i))
				buf_app[8*i +: 8] = c;
		end
	end

	// pending token as it would be emitted now
	always_comb begin
		fl        = '0;
		fl.text   = 64'(buf_q);
		fl.length = cnt_q;
		fl.trunc  = fl_trunc;
		case (mode_q)
			MODE_IDENT: begin
				fl.kind = KIND_IDENT;
				if (kw[4] && !fl_trunc) begin
					fl.kind = KIND_KEYWORD;
					fl.code = kw[3:0];
				end
			end
			MODE_NUMBER: fl.kind = KIND_NUMBER;
			MODE_OPWAIT: begin
				fl.kind   = KIND_OPERATOR;
				fl.code   = op_f[3:0];
				fl.text   = 64'(buf_q[7:0]);
				fl.length = 8'd1;
				fl.trunc  = 1'b0;
			end
			default: ;
		endcase
	end

	always_comb begin
		mode_n  = mode_q;
		buf_n   = buf_q;
		cnt_n   = cnt_q;
		tline_n = tline_q;
		tcol_n  = tcol_q;
		cline_n = cline_q;
		ccol_n  = ccol_q;
		a_v     = 1'b0;
		a       = fl;
		b_v     = 1'b0;
		b       = '0;
		b_line  = cline_q;
		b_col   = ccol_q;
		done    = 1'b0;
		flush   = 1'b0;
		if (is_end) begin
			a_v     = (mode_q != MODE_IDLE);
			b_v     = 1'b1;
			b.kind  = KIND_EOF;
			mode_n  = MODE_IDLE;
			buf_n   = '0;
			cnt_n   = '0;
			tline_n = POS_ONE;
			tcol_n  = POS_ONE;
			cline_n = POS_ONE;
			ccol_n  = POS_ONE;
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_alpha || is_digit || c == 8'h5f) begin
						done  = 1'b1;
						buf_n = buf_app;
						cnt_n = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;
					end else
						flush = 1'b1;
				end
				MODE_NUMBER: begin
					if (is_digit || c == 8'h2e) begin
						done  = 1'b1;
						buf_n = buf_app;
						cnt_n = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;
					end else
						flush = 1'b1;
				end
				MODE_OPWAIT: begin
					if (pair_hit) begin
						done     = 1'b1;
						a_v      = 1'b1;
						a        = '0;
						a.kind   = KIND_OPERATOR;
						a.code   = pair_code;
						a.text   = {48'd0, c, buf_q[7:0]};
						a.length = 8'd2;
						mode_n   = MODE_IDLE;
						buf_n    = '0;
						cnt_n    = '0;
					end else
						flush = 1'b1;
				end
				default: ;
			endcase
			if (flush) begin
				a_v    = 1'b1;
				mode_n = MODE_IDLE;
				buf_n  = '0;
				cnt_n  = '0;
			end
			if (!done && !is_skip) begin
				if (is_alpha || is_digit || is_opw) begin
					mode_n  = is_alpha ? MODE_IDENT : (is_digit ? MODE_NUMBER : MODE_OPWAIT);
					buf_n   = BW'(c);
					cnt_n   = 8'd1;
					tline_n = cline_q;
					tcol_n  = ccol_q;
				end else begin
					b_v      = 1'b1;
					b.text   = 64'(c);
					b.length = 8'd1;
					if (op_c[4]) begin
						b.kind = KIND_OPERATOR;
						b.code = op_c[3:0];
					end else if (c == 8'h3b)
						b.kind = KIND_STMT_END;
					else
						b.kind = KIND_INVALID;
				end
			end
			if (c == 8'h0a) begin
				cline_n = (cline_q == '1) ? cline_q : cline_q + POS_ONE;
				ccol_n  = POS_ONE;
			end else
				ccol_n = (ccol_q == '1) ? ccol_q : ccol_q + POS_ONE;
		end
	end

	// pack the results in order, last flag on the final one
	always_comb begin
		res0_v    = a_v || b_v;
		res1_v    = a_v && b_v;
		res0      = a_v ? a : b;
		res0_line = a_v ? tline_q : b_line;
		res0_col  = a_v ? tcol_q : b_col;
		res0.last = !(a_v && b_v);
		res1      = b;
		res1.last = 1'b1;
		res1_line = b_line;
		res1_col  = b_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			buf_q   <= '0;
			cnt_q   <= '0;
			tline_q <= POS_ONE;
			tcol_q  <= POS_ONE;
			cline_q <= POS_ONE;
			ccol_q  <= POS_ONE;
		end else if (proc) begin
			mode_q  <= mode_n;
			buf_q   <= buf_n;
			cnt_q   <= cnt_n;
			tline_q <= tline_n;
			tcol_q  <= tcol_n;
			cline_q <= cline_n;
			ccol_q  <= ccol_n;
		end
	end

endmodule

// ===== src/sct_outq.sv =====
module sct_outq import sct_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push0,
	input  tok_info_t                in0,
	input  logic [POSITION_BITS-1:0] in0_line,
	input  logic [POSITION_BITS-1:0] in0_col,
	input  logic                     push1,
	input  tok_info_t                in1,
	input  logic [POSITION_BITS-1:0] in1_line,
	input  logic [POSITION_BITS-1:0] in1_col,
	output logic                     room,
	output logic                     out_valid,
	input  logic                     out_stall,
	output tok_info_t                out_info,
	output logic [POSITION_BITS-1:0] out_line,
	output logic [POSITION_BITS-1:0] out_col
);

	localparam int DEPTH = 3;

	typedef struct packed {
		tok_info_t                info;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] col;
	} ent_t;

	ent_t       ent_q [DEPTH];
	ent_t       ent_n [DEPTH];
	logic [1:0] cnt_q, cnt_n, base;
	logic       pop;

	// two free slots needed before an item may be processed
	assign room      = cnt_q <= 2'd1;
	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_info  = ent_q[0].info;
	assign out_line  = ent_q[0].line;
	assign out_col   = ent_q[0].col;
	assign base      = cnt_q - 2'(pop);

	always_comb begin
		for (int i = 0; i < DEPTH - 1; i++)
			ent_n[i] = pop ? ent_q[i+1] : ent_q[i];
		ent_n[DEPTH-1] = ent_q[DEPTH-1];
		for (int i = 0; i < DEPTH; i++) begin
			if (push0 && base == 2'(i))
				ent_n[i] = '{info: in0, line: in0_line, col: in0_col};
			if (push1 && base + 2'd1 == 2'(i))
				ent_n[i] = '{info: in1, line: in1_line, col: in1_col};
		end
		cnt_n = base + 2'(push0) + 2'(push1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_n;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++)
			ent_q[i] <= ent_n[i];
	end

endmodule

// ===== src/sct_checker.sv =====
module sct_checker import sct_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     tok_valid,
	input logic                     tok_stall,
	input logic [2:0]               token_kind,
	input logic [63:0]              token_text,
	input logic [7:0]               token_length,
	input logic                     text_truncated,
	input logic [POSITION_BITS-1:0] start_line,
	input logic                     last_of_run
);

	// a stalled token stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid)
		else $error("token dropped while stalled");

	// end of file closes the run of its byte and carries no text
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == KIND_EOF |->
			last_of_run && token_length == 8'd0 && token_text == 64'd0)
		else $error("malformed end-of-file token");

	// single-byte kinds
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == KIND_STMT_END || token_kind == KIND_INVALID) |->
			token_length == 8'd1 && !text_truncated)
		else $error("single-byte token with wrong length");

	// a token that is not the last of its run is followed by one more
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_stall && !last_of_run |=> tok_valid)
		else $error("second token of a run missing");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> start_line != '0)
		else $error("line number zero");

endmodule

bind source_code_tokenizer sct_checker #(.POSITION_BITS(POSITION_BITS)) u_sct_checker (.*);
